>>> hw/rtl/sha256_block_compressor_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 block compressor assertion macros
// Shared concurrent assertion forms for the compressor RTL.
// ----------------------------------------------------------------------------
`ifndef SHA256_BLOCK_COMPRESSOR_MACROS_SVH
`define SHA256_BLOCK_COMPRESSOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SHAC_ASSERT_HOLDS(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("shac assertion failed");

// Next-cycle implication, disabled while in reset.
`define SHAC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("shac assertion failed");

`endif

>>> hw/rtl/shac_pkg.sv
// ----------------------------------------------------------------------------
// shac_pkg
// Types, constant tables and round functions of the SHA-256 block compressor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package shac_pkg;

    localparam int HASH_WORDS  = 8;
    localparam int ROUNDS      = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [31:0] message_word;
        logic        new_message;
    } shac_in_t;

    typedef struct packed {
        logic [31:0] hash_word;
        logic [2:0]  hash_index;
        logic        last;
    } shac_out_t;

    // One classified message word on its way from front to back.
    typedef struct packed {
        logic [31:0] word;
        logic        first;
        logic        fresh;
    } shac_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } shac_qstat_t;

    localparam word_t IV_TABLE [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sha256_block_compressor.sv
// ----------------------------------------------------------------------------
// sha256_block_compressor
// SHA-256 compression of 16-word blocks into eight chaining words.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | beat payload
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_valid / s_ready  | shac_in_t  {message_word, new_message}
//  m_      | out | m_valid / m_ready  | shac_out_t {hash_word, hash_index, last}
//
//  In the back end a block runs rounds 0..15, one per popped word, then
//  48 expansion rounds, then the chaining add. While the round engine works,
//  the queue still takes beats; sustained rate is set by the single round
//  unit. Results go out as eight beats, overlapped with absorbing the next
//  block. Reset (aresetn low, synchronous) reloads the initial hash values,
//  empties the queue and drops any partial block. s_ready drops only when the
//  four-entry queue is full; a stalled m_ready delays the next chaining add.
//
`timescale 1ns / 1ps
`default_nettype none

module sha256_block_compressor (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire shac_pkg::shac_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output shac_pkg::shac_out_t      m_data
);

    // Front, queue and core: classified words, queue status, push and pop.
    shac_pkg::shac_entry_t push_entry;
    shac_pkg::shac_entry_t pop_entry;
    shac_pkg::shac_qstat_t q_stat;
    logic                  q_push;
    logic                  q_pop;

    // Accept input beats and mark block starts.
    shac_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    // Decouple input from the round engine.
    shac_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    // Run rounds, update chaining values, emit the eight result beats.
    shac_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .q_entry (pop_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/shac_front.sv
// ----------------------------------------------------------------------------
// shac_front
// Input side: accepts message words and tags block starts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shac_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire shac_pkg::shac_in_t    s_data,
    input  wire shac_pkg::shac_qstat_t q_stat,
    output logic                       q_push,
    output shac_pkg::shac_entry_t      q_entry
);

    logic [3:0] count_reg;
    logic [3:0] count_next;

    assign s_ready = !q_stat.full;
    assign q_push  = s_valid && s_ready;

    // A word opens a block when it restarts the message or the count wraps.
    always_comb begin
        q_entry.word  = s_data.message_word;
        q_entry.fresh = s_data.new_message;
        q_entry.first = s_data.new_message || (count_reg == 4'd0);
        count_next    = (s_data.new_message ? 4'd0 : count_reg) + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
        end else if (q_push) begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/shac_queue.sv
// ----------------------------------------------------------------------------
// shac_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shac_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire shac_pkg::shac_entry_t push_entry,
    input  wire logic                  pop,
    output shac_pkg::shac_entry_t      pop_entry,
    output shac_pkg::shac_qstat_t      q_stat
);

    localparam int PTR_W  = shac_pkg::QPTR_W;
    localparam int QCNT_W = shac_pkg::QPTR_W + 1;

    shac_pkg::shac_entry_t           mem_reg [shac_pkg::QUEUE_DEPTH];
    logic [shac_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [shac_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [QCNT_W-1:0]               count_reg;

    assign pop_entry    = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(shac_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/shac_core.sv
// ----------------------------------------------------------------------------
// shac_core
// Round engine, schedule window, chaining update and result emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sha256_block_compressor_macros.svh"

module shac_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire shac_pkg::shac_qstat_t q_stat,
    input  wire shac_pkg::shac_entry_t q_entry,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output shac_pkg::shac_out_t        m_data
);

    localparam logic [1:0] PH_ABSORB = 2'd0;
    localparam logic [1:0] PH_EXPAND = 2'd1;
    localparam logic [1:0] PH_FINAL  = 2'd2;

    logic [1:0]              phase_reg;
    logic [1:0]              phase_next;
    logic [5:0]              round_reg;
    logic [5:0]              round_next;
    logic                    fresh_reg;
    logic                    emit_busy_reg;
    logic [2:0]              emit_idx_reg;
    logic                    m_valid_reg;
    shac_pkg::shac_out_t     m_data_reg;

    shac_pkg::word_t         cv_reg  [shac_pkg::HASH_WORDS];
    shac_pkg::word_t         v_reg   [shac_pkg::HASH_WORDS];
    shac_pkg::word_t         v_next  [shac_pkg::HASH_WORDS];
    shac_pkg::word_t         v_in    [shac_pkg::HASH_WORDS];
    shac_pkg::word_t         win_reg [16];
    shac_pkg::word_t         w_pre_reg;

    logic                    start_blk;
    logic                    round_en;
    logic                    do_final;
    logic                    out_load;
    logic [5:0]              t_idx;
    shac_pkg::word_t         w_exp;
    shac_pkg::word_t         w_cur;
    shac_pkg::word_t         t1;
    shac_pkg::word_t         t2;
    shac_pkg::word_t         ch;
    shac_pkg::word_t         maj;

    assign q_pop     = (phase_reg == PH_ABSORB) && !q_stat.empty;
    assign start_blk = q_pop && q_entry.first;
    assign round_en  = q_pop || (phase_reg == PH_EXPAND);
    assign do_final  = (phase_reg == PH_FINAL) && !emit_busy_reg;
    assign out_load  = !m_valid_reg || m_ready;
    assign t_idx     = start_blk ? 6'd0 : round_reg;

    // Expand the schedule word of the next round from fixed window taps;
    // it is registered so the round itself starts from a settled word.
    assign w_exp = win_reg[1] + shac_pkg::small_sigma0(win_reg[2]) + win_reg[10]
                 + shac_pkg::small_sigma1(win_reg[15]);
    assign w_cur = (phase_reg == PH_ABSORB) ? q_entry.word : w_pre_reg;

    always_comb begin
        for (int i = 0; i < shac_pkg::HASH_WORDS; i++) begin
            if (start_blk) begin
                v_in[i] = q_entry.fresh ? shac_pkg::IV_TABLE[i] : cv_reg[i];
            end else begin
                v_in[i] = v_reg[i];
            end
        end
        ch  = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
        maj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
        t1  = v_in[7] + shac_pkg::big_sigma1(v_in[4]) + ch + shac_pkg::K_TABLE[t_idx] + w_cur;
        t2  = shac_pkg::big_sigma0(v_in[0]) + maj;
        v_next[7] = v_in[6];
        v_next[6] = v_in[5];
        v_next[5] = v_in[4];
        v_next[4] = v_in[3] + t1;
        v_next[3] = v_in[2];
        v_next[2] = v_in[1];
        v_next[1] = v_in[0];
        v_next[0] = t1 + t2;
    end

    always_comb begin
        phase_next = phase_reg;
        round_next = round_reg;
        unique case (phase_reg)
            PH_ABSORB: begin
                if (q_pop) begin
                    round_next = t_idx + 6'd1;
                    if (t_idx == 6'd15) begin
                        phase_next = PH_EXPAND;
                    end
                end
            end
            PH_EXPAND: begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(shac_pkg::ROUNDS - 1)) begin
                    phase_next = PH_FINAL;
                end
            end
            PH_FINAL: begin
                if (do_final) begin
                    phase_next = PH_ABSORB;
                end
            end
            default: begin
                phase_next = PH_ABSORB;
                round_next = 6'd0;
            end
        endcase
    end

    // Working variables and window carry no reset.
    always_ff @(posedge aclk) begin
        if (round_en) begin
            for (int i = 0; i < shac_pkg::HASH_WORDS; i++) begin
                v_reg[i] <= v_next[i];
            end
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_cur;
            w_pre_reg   <= w_exp;
        end
        if (out_load && emit_busy_reg) begin
            m_data_reg.hash_word  <= cv_reg[emit_idx_reg];
            m_data_reg.hash_index <= emit_idx_reg;
            m_data_reg.last       <= (emit_idx_reg == 3'(shac_pkg::HASH_WORDS - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ABSORB;
            round_reg     <= 6'd0;
            fresh_reg     <= 1'b0;
            emit_busy_reg <= 1'b0;
            emit_idx_reg  <= 3'd0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < shac_pkg::HASH_WORDS; i++) begin
                cv_reg[i] <= shac_pkg::IV_TABLE[i];
            end
        end else begin
            phase_reg <= phase_next;
            round_reg <= round_next;
            if (start_blk) begin
                fresh_reg <= q_entry.fresh;
            end
            if (do_final) begin
                for (int i = 0; i < shac_pkg::HASH_WORDS; i++) begin
                    cv_reg[i] <= (fresh_reg ? shac_pkg::IV_TABLE[i] : cv_reg[i]) + v_reg[i];
                end
                emit_busy_reg <= 1'b1;
                emit_idx_reg  <= 3'd0;
            end else if (out_load && emit_busy_reg) begin
                emit_idx_reg <= emit_idx_reg + 3'd1;
                if (emit_idx_reg == 3'(shac_pkg::HASH_WORDS - 1)) begin
                    emit_busy_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_valid_reg <= emit_busy_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SHAC_ASSERT_HOLDS(a_pop_in_absorb, aclk, aresetn, q_pop, phase_reg == PH_ABSORB)
    `SHAC_ASSERT_HOLDS(a_last_on_h7, aclk, aresetn, m_valid, m_data.last == (m_data.hash_index == 3'd7))
    `SHAC_ASSERT_NEXT(a_final_waits, aclk, aresetn, phase_reg == PH_FINAL && emit_busy_reg, phase_reg == PH_FINAL)
    `SHAC_ASSERT_NEXT(a_emit_starts, aclk, aresetn, do_final, emit_busy_reg && emit_idx_reg == 3'd0)

endmodule

`default_nettype wire
